// ----- hw/rtl/dew_point_magnus_core_macros.svh -----
// ----------------------------------------------------------------------------
// dew point core assertion macros
// shared property shapes for the dew point pipeline checks
// ----------------------------------------------------------------------------
`ifndef DEW_POINT_MAGNUS_CORE_MACROS_SVH
`define DEW_POINT_MAGNUS_CORE_MACROS_SVH

// same-cycle implication
`define DPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error(msg);

// implication after a fixed number of cycles
`define DPM_ASSERT_DLY(label, clk, rst, ante, dly, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
   else $error(msg);

`endif

// ----- hw/rtl/dpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dpm_pkg
// constants and elaboration-time log table helpers for the dew point core
// ----------------------------------------------------------------------------
package dpm_pkg;

   localparam int LOG_TABLE_ENTRIES_DEF = 256;
   localparam int FRACTION_BITS_DEF     = 16;

   localparam int TEMP_W     = 12;
   localparam int HUM_W      = 10;
   localparam int DEW_W      = 11;
   localparam int EXP_W      = 4;
   localparam int FRAC_IDX_W = 9;
   localparam int TPROD_W    = 23;
   localparam int D1S_W      = 21;
   localparam int RATIO_DEN_W = 19;
   localparam int DEW_Q_W    = 12;

   localparam int B_X100     = 1762;
   localparam int C_X1000    = 243120;
   localparam int C_X100     = 24312;
   localparam int T_COEF     = 100;
   localparam int DEN_SCALE  = 10;
   localparam int HUM_FULL   = 1000;
   localparam int DEW_MIN    = -1000;
   localparam int DEW_MAX    = 850;

   // shift and subtract long division, only ever evaluated at elaboration
   function automatic longint unsigned udiv_const(input longint unsigned num,
                                                  input longint unsigned dvs);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int bi = 63; bi >= 0; bi--) begin
         rem = {rem[62:0], num[bi]};
         if (rem >= dvs) begin
            rem     = rem - dvs;
            quo[bi] = 1'b1;
         end
      end
      return quo;
   endfunction

   // ln(1 + i/n) in q.f, atanh series in q.32 then rounded
   function automatic longint unsigned log_rom_entry(input longint unsigned i,
                                                     input longint unsigned n,
                                                     input longint unsigned f);
      longint unsigned den;
      longint unsigned z;
      longint unsigned z2;
      longint unsigned p;
      longint unsigned sum;
      longint unsigned k;
      den = 2 * n + i;
      z   = udiv_const((i << 32) + (den >> 1), den);
      z2  = (z * z) >> 32;
      p   = z;
      sum = 0;
      k   = 1;
      while (k < 200 && p != 0) begin
         sum = sum + udiv_const(p, k);
         p   = (p * z2) >> 32;
         k   = k + 2;
      end
      sum = sum * 2;
      return (sum + (64'd1 << (31 - f))) >> (32 - f);
   endfunction

   // table log of a constant humidity code
   function automatic longint unsigned ln_fixed_const(input longint unsigned h,
                                                      input longint unsigned n,
                                                      input longint unsigned f);
      longint unsigned e;
      longint unsigned u;
      longint unsigned idx;
      longint unsigned fr;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned v;
      e = 0;
      for (int k = 1; k < 32; k++) begin
         if ((h >> k) != 0) e = 64'(k);
      end
      u   = (h - (64'd1 << e)) * n;
      idx = u >> e;
      fr  = u & ((64'd1 << e) - 1);
      lo  = log_rom_entry(idx, n, f);
      hi  = log_rom_entry(idx + 1, n, f);
      v   = lo;
      if (e > 0) v = v + (((hi - lo) * fr + (64'd1 << (e - 1))) >> e);
      return e * log_rom_entry(n, n, f) + v;
   endfunction

endpackage

// ----- hw/rtl/dpm_div_pipe.sv -----
// ----------------------------------------------------------------------------
// dpm_div_pipe
// restoring divider, one quotient bit per register stage, sideband carried
// ----------------------------------------------------------------------------
module dpm_div_pipe #(
   parameter int NW = 40,
   parameter int DW = 19,
   parameter int QW = 23,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic [CW-1:0] rem_ff  [QW];
   logic [CW-1:0] rem_in  [QW];
   logic [CW-1:0] rem_src [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [DW-1:0] den_src [QW];
   logic [QW-1:0] quot_ff [QW];
   logic [QW-1:0] quot_in [QW];
   logic [QW-1:0] quot_src[QW];
   logic [SW-1:0] side_ff [QW];
   logic [SW-1:0] side_src[QW];
   logic [QW-1:0] valid_ff;
   logic [QW-1:0] valid_in;

   always_comb begin
      logic [CW-1:0] step;
      rem_src[0]  = CW'(in_num);
      den_src[0]  = in_den;
      quot_src[0] = '0;
      side_src[0] = in_side;
      valid_in[0] = in_valid;
      for (int j = 1; j < QW; j++) begin
         rem_src[j]  = rem_ff[j-1];
         den_src[j]  = den_ff[j-1];
         quot_src[j] = quot_ff[j-1];
         side_src[j] = side_ff[j-1];
         valid_in[j] = valid_ff[j-1];
      end
      // stage j settles quotient bit QW-1-j
      for (int j = 0; j < QW; j++) begin
         step = CW'(den_src[j]) << (QW - 1 - j);
         if (rem_src[j] >= step) begin
            rem_in[j]  = rem_src[j] - step;
            quot_in[j] = quot_src[j] | (QW'(1) << (QW - 1 - j));
         end else begin
            rem_in[j]  = rem_src[j];
            quot_in[j] = quot_src[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         rem_ff[j]  <= rem_in[j];
         den_ff[j]  <= den_src[j];
         quot_ff[j] <= quot_in[j];
         side_ff[j] <= side_src[j];
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ----- hw/rtl/dew_point_magnus_core.sv -----
// ----------------------------------------------------------------------------
// dew_point_magnus_core
// magnus dew point from one temperature / humidity reading, fixed point
// ----------------------------------------------------------------------------
// path: start, stage a, ratio divider, stages b to f, dew point divider, stage g to rsp_strobe
// throughput: one reading per cycle, busy is low outside reset
// most of the latency comes from the two bit-per-stage dividers (ratio and final quotient)
// reset: synchronous, clears all stage valid bits, no result in flight survives
// results cannot be held off: each is shown for exactly one cycle
module dew_point_magnus_core #(
   parameter int LOG_TABLE_ENTRIES = dpm_pkg::LOG_TABLE_ENTRIES_DEF,
   parameter int FRACTION_BITS     = dpm_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [dpm_pkg::TEMP_W-1:0] req_temperature,
   input  logic        [dpm_pkg::HUM_W-1:0]  req_humidity,
   input  logic                              req_reading_ok,
   output logic                              rsp_strobe,
   output logic signed [dpm_pkg::DEW_W-1:0]  rsp_dew_point,
   output logic                              rsp_dew_valid
);

   `include "dew_point_magnus_core_macros.svh"

   // ------------------------------------------------------------------ sizes
   localparam int N   = LOG_TABLE_ENTRIES;
   localparam int F   = FRACTION_BITS;
   localparam int IW  = $clog2(N);
   localparam int RIW = $clog2(N + 1);
   localparam int RW  = F;                          // ln table entries, all below 1.0
   localparam int LW  = F + 8;                      // lambda, signed, |lambda| < 128
   localparam int UW  = dpm_pkg::FRAC_IDX_W + RIW;
   localparam int PW  = RW + dpm_pkg::FRAC_IDX_W + 1;
   localparam int QW1 = F + 7;
   localparam int NW1 = F + 23;
   localparam int DW1 = dpm_pkg::RATIO_DEN_W;
   localparam int DENW = F + 7;
   localparam int NW2 = F + 22;
   localparam int DW2 = F + 11;
   localparam int QW2 = dpm_pkg::DEW_Q_W;
   localparam int TDW = QW2 + 1;
   localparam int LAT = QW1 + QW2 + 7;

   localparam longint BFX = (longint'(dpm_pkg::B_X100) * (longint'(1) << F) + 50) / 100;
   localparam logic signed [LW-1:0] BFX_S    = LW'(BFX);
   localparam logic signed [LW-1:0] LN1000_S =
      LW'(dpm_pkg::ln_fixed_const(64'(dpm_pkg::HUM_FULL), 64'(N), 64'(F)));
   localparam logic signed [LW-1:0] ROMN_S   =
      LW'(dpm_pkg::log_rom_entry(64'(N), 64'(N), 64'(F)));
   localparam logic signed [TDW-1:0] TD_MIN  = TDW'(dpm_pkg::DEW_MIN);
   localparam logic signed [TDW-1:0] TD_MAX  = TDW'(dpm_pkg::DEW_MAX);
   localparam logic signed [dpm_pkg::DEW_W-1:0] DEW_MIN_S = dpm_pkg::DEW_W'(dpm_pkg::DEW_MIN);
   localparam logic signed [dpm_pkg::DEW_W-1:0] DEW_MAX_S = dpm_pkg::DEW_W'(dpm_pkg::DEW_MAX);

   typedef struct packed {
      logic                              ok;
      logic                              neg;
      logic [dpm_pkg::EXP_W-1:0]         e;
      logic [IW-1:0]                     idx;
      logic [dpm_pkg::FRAC_IDX_W-1:0]    fr;
   } side1_type;

   typedef struct packed {
      logic ok;
      logic neg;
   } side2_type;

   // ------------------------------------------------------------- ln table
   logic [RW-1:0] rom_tab [N+1];

   for (genvar g = 0; g <= N; g++) begin : g_rom
      assign rom_tab[g] = RW'(dpm_pkg::log_rom_entry(64'(g), 64'(N), 64'(F)));
   end

   // pipeline never stalls, only reset holds off a transfer
   assign busy = reset;

   // ------------------------------------------------ stage a: operand setup
   logic                             a_valid_in, a_valid_ff;
   logic [NW1-1:0]                   a_num_in, a_num_ff;
   logic [DW1-1:0]                   a_den_in, a_den_ff;
   side1_type                        a_side_in, a_side_ff;
   logic [dpm_pkg::FRAC_IDX_W-1:0]   hum_rem_a;
   logic [UW-1:0]                    u_a;
   logic signed [dpm_pkg::TPROD_W-1:0] tp_a;
   logic [dpm_pkg::TPROD_W-2:0]      tmag_a;
   logic signed [dpm_pkg::D1S_W-1:0] d1s_a;

   always_comb begin
      a_valid_in   = start && !busy;
      // floor(log2 h) by priority over the humidity bits
      a_side_in.e  = '0;
      for (int i = 1; i < dpm_pkg::HUM_W; i++) begin
         if (req_humidity[i]) a_side_in.e = dpm_pkg::EXP_W'(i);
      end
      hum_rem_a     = dpm_pkg::FRAC_IDX_W'(req_humidity - (dpm_pkg::HUM_W'(1) << a_side_in.e));
      u_a           = UW'(hum_rem_a) * UW'(N);
      a_side_in.idx = IW'(u_a >> a_side_in.e);
      a_side_in.fr  = dpm_pkg::FRAC_IDX_W'(u_a & ~({UW{1'b1}} << a_side_in.e));
      a_side_in.ok  = req_reading_ok && (req_humidity != '0)
                      && (req_humidity <= dpm_pkg::HUM_W'(dpm_pkg::HUM_FULL));
      // b*T/(c+T) as 1762*T*2^F / (243120 + 100*T), sign and magnitude
      tp_a          = dpm_pkg::TPROD_W'(req_temperature) * dpm_pkg::TPROD_W'(dpm_pkg::B_X100);
      a_side_in.neg = tp_a[dpm_pkg::TPROD_W-1];
      tmag_a        = (dpm_pkg::TPROD_W-1)'(a_side_in.neg ? -tp_a : tp_a);
      d1s_a         = dpm_pkg::D1S_W'(dpm_pkg::C_X1000)
                      + dpm_pkg::D1S_W'(req_temperature) * dpm_pkg::D1S_W'(dpm_pkg::T_COEF);
      a_den_in      = DW1'(d1s_a);
      // half the divisor added for round half away from zero
      a_num_in      = (NW1'(tmag_a) << F) + NW1'(a_den_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_num_ff  <= a_num_in;
      a_den_ff  <= a_den_in;
      a_side_ff <= a_side_in;
   end

   // ------------------------------------------------- ratio divider stages
   logic             d1_valid;
   logic [QW1-1:0]   d1_quot;
   logic [$bits(side1_type)-1:0] d1_side_bits;
   side1_type        d1_side;

   dpm_div_pipe #(
      .NW (NW1),
      .DW (DW1),
      .QW (QW1),
      .SW ($bits(side1_type))
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_num    (a_num_ff),
      .in_den    (a_den_ff),
      .in_side   (a_side_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_side_bits)
   );

   assign d1_side = side1_type'(d1_side_bits);

   // ---------------------------------------------- stage b: ln table lookup
   logic                           b_valid_ff, b_ok_ff;
   logic [RW-1:0]                  b_lo_in, b_lo_ff, b_diff_in, b_diff_ff;
   logic [dpm_pkg::FRAC_IDX_W-1:0] b_fr_ff;
   logic [dpm_pkg::EXP_W-1:0]      b_e_ff;
   logic signed [LW-1:0]           b_ratio_in, b_ratio_ff;

   always_comb begin
      b_lo_in    = rom_tab[RIW'(d1_side.idx)];
      b_diff_in  = rom_tab[RIW'(d1_side.idx) + RIW'(1)] - b_lo_in;
      b_ratio_in = d1_side.neg ? -$signed({1'b0, d1_quot}) : $signed({1'b0, d1_quot});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      b_ok_ff    <= d1_side.ok;
      b_lo_ff    <= b_lo_in;
      b_diff_ff  <= b_diff_in;
      b_fr_ff    <= d1_side.fr;
      b_e_ff     <= d1_side.e;
      b_ratio_ff <= b_ratio_in;
   end

   // ---------------------------------------- stage c: interpolation product
   logic                      c_valid_ff, c_ok_ff;
   logic [PW-1:0]             c_prod_in, c_prod_ff;
   logic [RW-1:0]             c_lo_ff;
   logic [dpm_pkg::EXP_W-1:0] c_e_ff;
   logic signed [LW-1:0]      c_ratio_ff;

   assign c_prod_in = PW'(b_diff_ff) * PW'(b_fr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_ok_ff    <= b_ok_ff;
      c_prod_ff  <= c_prod_in;
      c_lo_ff    <= b_lo_ff;
      c_e_ff     <= b_e_ff;
      c_ratio_ff <= b_ratio_ff;
   end

   // ------------------------------------------------------ stage d: lambda
   logic                 d_valid_ff, d_ok_ff;
   logic [PW-1:0]        d_rnd, d_interp;
   logic signed [LW-1:0] d_lambda_in, d_lambda_ff;

   always_comb begin
      d_rnd       = (c_e_ff == '0) ? '0 : (PW'(1) << (c_e_ff - dpm_pkg::EXP_W'(1)));
      d_interp    = (c_prod_ff + d_rnd) >> c_e_ff;
      // ln(h) - ln(1000) keeps the log term exactly zero at full humidity
      d_lambda_in = $signed(LW'(c_e_ff)) * ROMN_S + $signed(LW'(c_lo_ff))
                    + $signed(LW'(d_interp)) - LN1000_S + c_ratio_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_ok_ff     <= c_ok_ff;
      d_lambda_ff <= d_lambda_in;
   end

   // ------------------------------------ stage e: numerator and denominator
   logic                  e_valid_ff, e_ok_ff;
   logic signed [NW2:0]   e_num_in, e_num_ff;
   logic [DENW-1:0]       e_den_in, e_den_ff;

   always_comb begin
      e_num_in = (NW2+1)'(d_lambda_ff) * (NW2+1)'(dpm_pkg::C_X100);
      // b - lambda stays positive for every 12-bit temperature
      e_den_in = DENW'(BFX_S - d_lambda_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_ok_ff  <= d_ok_ff;
      e_num_ff <= e_num_in;
      e_den_ff <= e_den_in;
   end

   // ---------------------------------------- stage f: divider 2 operands
   logic            f_valid_ff;
   side2_type       f_side_in, f_side_ff;
   logic [NW2-1:0]  f_num_in, f_num_ff;
   logic [DW2-1:0]  f_den_in, f_den_ff;

   always_comb begin
      f_side_in.ok  = e_ok_ff;
      f_side_in.neg = e_num_ff[NW2];
      f_num_in      = NW2'(f_side_in.neg ? -e_num_ff : e_num_ff)
                      + NW2'(e_den_ff) * NW2'(dpm_pkg::DEN_SCALE / 2);
      f_den_in      = DW2'(e_den_ff) * DW2'(dpm_pkg::DEN_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_side_ff <= f_side_in;
      f_num_ff  <= f_num_in;
      f_den_ff  <= f_den_in;
   end

   // ------------------------------------------------ dew point divider
   logic                          d2_valid;
   logic [QW2-1:0]                d2_quot;
   logic [$bits(side2_type)-1:0]  d2_side_bits;
   side2_type                     d2_side;

   dpm_div_pipe #(
      .NW (NW2),
      .DW (DW2),
      .QW (QW2),
      .SW ($bits(side2_type))
   ) u_dew_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid_ff),
      .in_num    (f_num_ff),
      .in_den    (f_den_ff),
      .in_side   (f_side_ff),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_side  (d2_side_bits)
   );

   assign d2_side = side2_type'(d2_side_bits);

   // ------------------------------------ stage g: sign, saturate, register
   logic                              out_strobe_ff, out_valid_in, out_valid_ff;
   logic signed [TDW-1:0]             g_td;
   logic signed [dpm_pkg::DEW_W-1:0]  out_dew_in, out_dew_ff;

   always_comb begin
      g_td = d2_side.neg ? -$signed({1'b0, d2_quot}) : $signed({1'b0, d2_quot});
      if (g_td < TD_MIN) begin
         g_td = TD_MIN;
      end else if (g_td > TD_MAX) begin
         g_td = TD_MAX;
      end
      out_valid_in = d2_side.ok;
      // failed or out-of-range readings report zero
      out_dew_in   = d2_side.ok ? dpm_pkg::DEW_W'(g_td) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_valid_ff <= out_valid_in;
      out_dew_ff   <= out_dew_in;
   end

   assign rsp_strobe    = out_strobe_ff;
   assign rsp_dew_point = out_dew_ff;
   assign rsp_dew_valid = out_valid_ff;

   // ----------------------------------------------------------- assertions
   `DPM_ASSERT_DLY(a_fixed_latency, clock, reset, start && !busy, LAT, rsp_strobe,
                   "accepted reading did not give a result after the pipeline latency")
   `DPM_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_strobe && !rsp_dew_valid,
                   rsp_dew_point == '0, "invalid result carries a non-zero dew point")
   `DPM_ASSERT_IMP(a_dew_range, clock, reset, rsp_strobe,
                   (rsp_dew_point >= DEW_MIN_S) && (rsp_dew_point <= DEW_MAX_S),
                   "dew point outside the saturation range")

endmodule
